// ----- design/i2cts_pkg.sv -----
// i2cts_pkg: shared types, codes and status constants for the i2c transaction sequencer
// used by i2cts_step, i2cts_out_reg and i2c_master_transaction_sequencer; no dependencies
package i2cts_pkg;

    // transaction phase
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_WSTART = 3'd1,
        PH_WADDR  = 3'd2,
        PH_WDATA  = 3'd3,
        PH_RSTART = 3'd4,
        PH_RADDR  = 3'd5,
        PH_RACK   = 3'd6,
        PH_RNACK  = 3'd7
    } phase_t;

    // commands to the bus engine
    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_SEND  = 3'd2,
        CMD_RACK  = 3'd3,
        CMD_RNACK = 3'd4,
        CMD_STOP  = 3'd5
    } cmd_t;

    // transaction outcome
    typedef enum logic [1:0] {
        OUT_SUCCESS = 2'd0,
        OUT_NAK     = 2'd1,
        OUT_BAD     = 2'd2
    } outcome_t;

    // word kinds on the input channel
    localparam logic MODE_BEGIN = 1'b0;
    localparam logic MODE_EVENT = 1'b1;

    // bus engine status codes (upper five bits)
    localparam logic [7:0] STATUS_MASK     = 8'hf8;
    localparam logic [7:0] ST_START        = 8'h08;
    localparam logic [7:0] ST_RESTART      = 8'h10;
    localparam logic [7:0] ST_SLAW_ACK     = 8'h18;
    localparam logic [7:0] ST_SLAW_NAK     = 8'h20;
    localparam logic [7:0] ST_DATAW_ACK    = 8'h28;
    localparam logic [7:0] ST_DATAW_NAK    = 8'h30;
    localparam logic [7:0] ST_SLAR_ACK     = 8'h40;
    localparam logic [7:0] ST_SLAR_NAK     = 8'h48;
    localparam logic [7:0] ST_DATAR_ACK    = 8'h50;
    localparam logic [7:0] ST_DATAR_NAK    = 8'h58;
    localparam logic [7:0] ADDR_WRITE_MASK = 8'hfe;
    localparam logic [7:0] ADDR_READ_BIT   = 8'h01;

    // one input word
    typedef struct packed {
        logic        mode;
        logic [7:0]  slave_addr;
        logic [15:0] addr_count;
        logic [15:0] write_count;
        logic [15:0] read_count;
        logic [7:0]  bus_status;
        logic [7:0]  rx_byte;
        logic [7:0]  tx_byte;
    } item_t;

    // one result word
    typedef struct packed {
        cmd_t       bus_command;
        logic [7:0] bus_byte;
        logic [7:0] rx_data;
        logic       rx_valid;
        logic       done_res;
        outcome_t   outcome;
        logic [7:0] failing_status;
    } result_t;

    // sequencer context carried between words
    typedef struct packed {
        phase_t      phase;
        logic [7:0]  target_address;
        logic [16:0] bytes_to_write;
        logic [15:0] bytes_to_read;
        logic        has_written;
    } ctx_t;

endpackage

// ----- design/i2cts_step.sv -----
// i2cts_step: combinational next-context and result for one input word
// depends on i2cts_pkg
module i2cts_step
    import i2cts_pkg::*;
(
    input  item_t   item,
    input  ctx_t    ctx,
    output ctx_t    ctx_next,
    output result_t res
);

    logic [7:0]  st;
    logic [16:0] total_write;
    logic [15:0] read_dec;
    logic        wr_ack_hit;
    logic        wr_nak_hit;
    logic        restart_hit;

    // masked status, write total and per-phase expected codes
    assign st          = item.bus_status & STATUS_MASK;
    assign total_write = {1'b0, item.addr_count} + {1'b0, item.write_count};
    assign read_dec    = (ctx.bytes_to_read != 16'd0) ? ctx.bytes_to_read - 16'd1
                                                      : ctx.bytes_to_read;
    assign wr_ack_hit  = (ctx.phase == PH_WADDR) ? (st == ST_SLAW_ACK) : (st == ST_DATAW_ACK);
    assign wr_nak_hit  = (ctx.phase == PH_WADDR) ? (st == ST_SLAW_NAK) : (st == ST_DATAW_NAK);
    assign restart_hit = ctx.has_written ? (st == ST_RESTART) : (st == ST_START);

    // phase decode and command selection
    always_comb begin
        ctx_next           = ctx;
        res.bus_command    = CMD_NONE;
        res.bus_byte       = 8'd0;
        res.rx_data        = 8'd0;
        res.rx_valid       = 1'b0;
        res.done_res       = 1'b0;
        res.outcome        = OUT_SUCCESS;
        res.failing_status = 8'd0;

        if (item.mode == MODE_BEGIN) begin
            ctx_next.target_address = item.slave_addr;
            ctx_next.bytes_to_write = total_write;
            ctx_next.bytes_to_read  = item.read_count;
            if (total_write != 17'd0) begin
                ctx_next.has_written = 1'b1;
                ctx_next.phase       = PH_WSTART;
                res.bus_command      = CMD_START;
            end else if (item.read_count != 16'd0) begin
                ctx_next.has_written = 1'b0;
                ctx_next.phase       = PH_RSTART;
                res.bus_command      = CMD_START;
            end else begin
                // empty transaction ends at once
                ctx_next.has_written = 1'b0;
                ctx_next.phase       = PH_IDLE;
                res.done_res         = 1'b1;
            end
        end else begin
            case (ctx.phase)
                PH_WSTART: begin
                    if (st == ST_START) begin
                        res.bus_command = CMD_SEND;
                        res.bus_byte    = ctx.target_address & ADDR_WRITE_MASK;
                        ctx_next.phase  = PH_WADDR;
                    end else begin
                        ctx_next.phase     = PH_IDLE;
                        res.done_res       = 1'b1;
                        res.outcome        = OUT_BAD;
                        res.failing_status = st;
                    end
                end
                PH_WADDR, PH_WDATA: begin
                    if (wr_ack_hit) begin
                        if (ctx.bytes_to_write != 17'd0) begin
                            res.bus_command         = CMD_SEND;
                            res.bus_byte            = item.tx_byte;
                            ctx_next.bytes_to_write = ctx.bytes_to_write - 17'd1;
                            ctx_next.phase          = PH_WDATA;
                        end else if (ctx.bytes_to_read != 16'd0) begin
                            // repeated start for the read part
                            res.bus_command = CMD_START;
                            ctx_next.phase  = PH_RSTART;
                        end else begin
                            res.bus_command = CMD_STOP;
                            ctx_next.phase  = PH_IDLE;
                            res.done_res    = 1'b1;
                        end
                    end else if (wr_nak_hit) begin
                        res.bus_command    = CMD_STOP;
                        ctx_next.phase     = PH_IDLE;
                        res.done_res       = 1'b1;
                        res.outcome        = OUT_NAK;
                        res.failing_status = st;
                    end else begin
                        ctx_next.phase     = PH_IDLE;
                        res.done_res       = 1'b1;
                        res.outcome        = OUT_BAD;
                        res.failing_status = st;
                    end
                end
                PH_RSTART: begin
                    if (restart_hit) begin
                        res.bus_command = CMD_SEND;
                        res.bus_byte    = ctx.target_address | ADDR_READ_BIT;
                        ctx_next.phase  = PH_RADDR;
                    end else begin
                        ctx_next.phase     = PH_IDLE;
                        res.done_res       = 1'b1;
                        res.outcome        = OUT_BAD;
                        res.failing_status = st;
                    end
                end
                PH_RADDR: begin
                    if (st == ST_SLAR_ACK) begin
                        if (|ctx.bytes_to_read[15:1]) begin
                            res.bus_command = CMD_RACK;
                            ctx_next.phase  = PH_RACK;
                        end else begin
                            res.bus_command = CMD_RNACK;
                            ctx_next.phase  = PH_RNACK;
                        end
                    end else if (st == ST_SLAR_NAK) begin
                        res.bus_command    = CMD_STOP;
                        ctx_next.phase     = PH_IDLE;
                        res.done_res       = 1'b1;
                        res.outcome        = OUT_NAK;
                        res.failing_status = st;
                    end else begin
                        ctx_next.phase     = PH_IDLE;
                        res.done_res       = 1'b1;
                        res.outcome        = OUT_BAD;
                        res.failing_status = st;
                    end
                end
                PH_RACK: begin
                    if (st == ST_DATAR_ACK) begin
                        res.rx_data            = item.rx_byte;
                        res.rx_valid           = 1'b1;
                        ctx_next.bytes_to_read = read_dec;
                        if (|read_dec[15:1]) begin
                            res.bus_command = CMD_RACK;
                            ctx_next.phase  = PH_RACK;
                        end else begin
                            res.bus_command = CMD_RNACK;
                            ctx_next.phase  = PH_RNACK;
                        end
                    end else begin
                        ctx_next.phase     = PH_IDLE;
                        res.done_res       = 1'b1;
                        res.outcome        = OUT_BAD;
                        res.failing_status = st;
                    end
                end
                PH_RNACK: begin
                    if (st == ST_DATAR_NAK) begin
                        res.rx_data            = item.rx_byte;
                        res.rx_valid           = 1'b1;
                        ctx_next.bytes_to_read = 16'd0;
                        res.bus_command        = CMD_STOP;
                        ctx_next.phase         = PH_IDLE;
                        res.done_res           = 1'b1;
                    end else begin
                        ctx_next.phase     = PH_IDLE;
                        res.done_res       = 1'b1;
                        res.outcome        = OUT_BAD;
                        res.failing_status = st;
                    end
                end
                default: begin
                    // event while idle is ignored
                    ctx_next.phase = PH_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- design/i2cts_out_reg.sv -----
// i2cts_out_reg: result register stage with valid/ready toward the master side
// depends on i2cts_pkg
module i2cts_out_reg
    import i2cts_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t res_in,
    output logic    can_load,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t res_out
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign res_out   = res_reg;

    // hold until taken, refill in the same cycle
    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

endmodule

// ----- design/i2c_master_transaction_sequencer.sv -----
// i2c_master_transaction_sequencer: top level, input register, context registers, checks
// depends on i2cts_pkg, i2cts_step, i2cts_out_reg
//
//   channel | ports                       | word
//   --------+-----------------------------+-------------------------------------------
//   input   | s_tvalid s_tready s_tdata   | begin (tuser 0) or bus engine event (1)
//           | s_tuser                     |
//   result  | m_tvalid m_tready m_tdata   | next command, received byte, outcome;
//           | m_tlast                     | tlast marks the end of a transaction
//
// one word per cycle while m_tready does not stall; a word is captured in the input register
// and then, through the step logic, in the result register
// the phase compare and one counter decrement sit between the two registers
// reset clears the valid flags and the context to idle; no clearing pass
// a stall on m_tready backs up through both registers to s_tready
module i2c_master_transaction_sequencer
    import i2cts_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // slave_addr[7:0] addr_count[23:8] write_count[39:24] read_count[55:40]
    // bus_status[63:56] rx_byte[71:64] tx_byte[79:72]
    input  logic [79:0] s_tdata,
    // mode[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // bus_command[2:0] bus_byte[10:3] rx_data[18:11] rx_valid[19] outcome[21:20]
    // failing_status[29:22] zero[31:30]
    output logic [31:0] m_tdata,
    // done_res
    output logic        m_tlast
);

    item_t   item_reg;
    logic    in_valid_reg;
    logic    in_valid_next;
    ctx_t    ctx_reg;
    ctx_t    ctx_step;
    result_t res_step;
    result_t res_out;
    logic    out_can_load;
    logic    step_fire;
    logic    in_fire;

    // input register handshake
    assign step_fire = in_valid_reg && out_can_load;
    assign s_tready  = !in_valid_reg || out_can_load;
    assign in_fire   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_fire) begin
            in_valid_next = 1'b1;
        end else if (step_fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // unpack the input word
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            item_reg.mode        <= s_tuser;
            item_reg.slave_addr  <= s_tdata[7:0];
            item_reg.addr_count  <= s_tdata[23:8];
            item_reg.write_count <= s_tdata[39:24];
            item_reg.read_count  <= s_tdata[55:40];
            item_reg.bus_status  <= s_tdata[63:56];
            item_reg.rx_byte     <= s_tdata[71:64];
            item_reg.tx_byte     <= s_tdata[79:72];
        end
    end

    // per-word sequencing logic
    i2cts_step u_step (
        .item     (item_reg),
        .ctx      (ctx_reg),
        .ctx_next (ctx_step),
        .res      (res_step)
    );

    // transaction context
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctx_reg.phase          <= PH_IDLE;
            ctx_reg.target_address <= 8'd0;
            ctx_reg.bytes_to_write <= 17'd0;
            ctx_reg.bytes_to_read  <= 16'd0;
            ctx_reg.has_written    <= 1'b0;
        end else if (step_fire) begin
            ctx_reg <= ctx_step;
        end
    end

    // result register
    i2cts_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (step_fire),
        .res_in    (res_step),
        .can_load  (out_can_load),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .res_out   (res_out)
    );

    // pack the result word
    assign m_tdata = {2'b00, res_out.failing_status, res_out.outcome, res_out.rx_valid,
                      res_out.rx_data, res_out.bus_byte, res_out.bus_command};
    assign m_tlast = res_out.done_res;

    // a failure outcome only ever comes with the end of the transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (res_out.outcome != OUT_SUCCESS) |-> res_out.done_res)
        else $error("failure outcome without done");

    // success never reports a failing status
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (res_out.outcome == OUT_SUCCESS) |-> (res_out.failing_status == 8'd0))
        else $error("failing status on success");

    // a received byte comes only with a receive or stop command
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_out.rx_valid |->
            (res_out.bus_command == CMD_RACK) || (res_out.bus_command == CMD_RNACK) ||
            (res_out.bus_command == CMD_STOP))
        else $error("received byte with wrong command");

    // a finished transaction leaves the context idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_fire && res_step.done_res |=> (ctx_reg.phase == PH_IDLE))
        else $error("context not idle after done");

endmodule

// ----- sim/tb_i2c_master_transaction_sequencer.sv -----
// tb_i2c_master_transaction_sequencer: self-checking testbench that replays i2c write, read
// and write-then-read transactions, predicting every result word; needs i2cts_pkg and the rtl
module tb_i2c_master_transaction_sequencer;
    import i2cts_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    // sequencer state as the predictor sees it
    phase_t      seq_phase = PH_IDLE;
    logic [7:0]  seq_target = '0;
    logic [16:0] seq_write_left = '0;
    logic [15:0] seq_read_left = '0;
    logic        seq_wrote = 1'b0;

    result_t     result_q[$];
    int          words_sent = 0;
    int          err_count = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          cycle_count = 0;
    int          hold_until = 0;
    int          n_closed = 0;
    int          n_nak = 0;
    int          n_bad = 0;
    int          n_rx = 0;

    i2c_master_transaction_sequencer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

    // end the running transaction
    function automatic void close_txn(inout result_t r, input outcome_t oc,
                                      input logic [7:0] st);
        seq_phase = PH_IDLE;
        r.done_res = 1'b1;
        r.outcome = oc;
        r.failing_status = (oc == OUT_SUCCESS) ? 8'h00 : st;
    endfunction

    // next receive command from the bytes still to read
    function automatic void pick_receive(inout result_t r);
        if (seq_read_left >= 16'd2) begin
            r.bus_command = CMD_RACK;
            seq_phase = PH_RACK;
        end else begin
            r.bus_command = CMD_RNACK;
            seq_phase = PH_RNACK;
        end
    endfunction

    // result word for one input word, advancing the predicted state
    function automatic result_t predict_result(input item_t w);
        result_t    r;
        logic [7:0] st;
        logic [7:0] ack_code;
        logic [7:0] nak_code;
        r = '0;
        st = w.bus_status & STATUS_MASK;
        if (w.mode == MODE_BEGIN) begin
            seq_target = w.slave_addr;
            seq_write_left = {1'b0, w.addr_count} + {1'b0, w.write_count};
            seq_read_left = w.read_count;
            seq_wrote = (seq_write_left != 17'd0);
            if (seq_write_left != 17'd0) begin
                r.bus_command = CMD_START;
                seq_phase = PH_WSTART;
            end else if (seq_read_left != 16'd0) begin
                r.bus_command = CMD_START;
                seq_phase = PH_RSTART;
            end else begin
                close_txn(r, OUT_SUCCESS, st);
            end
            return r;
        end
        case (seq_phase)
            PH_WSTART: begin
                if (st == ST_START) begin
                    r.bus_command = CMD_SEND;
                    r.bus_byte = seq_target & ADDR_WRITE_MASK;
                    seq_phase = PH_WADDR;
                end else begin
                    close_txn(r, OUT_BAD, st);
                end
            end
            PH_WADDR, PH_WDATA: begin
                ack_code = (seq_phase == PH_WADDR) ? ST_SLAW_ACK : ST_DATAW_ACK;
                nak_code = (seq_phase == PH_WADDR) ? ST_SLAW_NAK : ST_DATAW_NAK;
                if (st == ack_code) begin
                    if (seq_write_left != 17'd0) begin
                        r.bus_command = CMD_SEND;
                        r.bus_byte = w.tx_byte;
                        seq_write_left = seq_write_left - 17'd1;
                        seq_phase = PH_WDATA;
                    end else if (seq_read_left != 16'd0) begin
                        r.bus_command = CMD_START;
                        seq_phase = PH_RSTART;
                    end else begin
                        r.bus_command = CMD_STOP;
                        close_txn(r, OUT_SUCCESS, st);
                    end
                end else if (st == nak_code) begin
                    r.bus_command = CMD_STOP;
                    close_txn(r, OUT_NAK, st);
                end else begin
                    close_txn(r, OUT_BAD, st);
                end
            end
            PH_RSTART: begin
                if (st == (seq_wrote ? ST_RESTART : ST_START)) begin
                    r.bus_command = CMD_SEND;
                    r.bus_byte = seq_target | ADDR_READ_BIT;
                    seq_phase = PH_RADDR;
                end else begin
                    close_txn(r, OUT_BAD, st);
                end
            end
            PH_RADDR: begin
                if (st == ST_SLAR_ACK) begin
                    pick_receive(r);
                end else if (st == ST_SLAR_NAK) begin
                    r.bus_command = CMD_STOP;
                    close_txn(r, OUT_NAK, st);
                end else begin
                    close_txn(r, OUT_BAD, st);
                end
            end
            PH_RACK: begin
                if (st == ST_DATAR_ACK) begin
                    r.rx_data = w.rx_byte;
                    r.rx_valid = 1'b1;
                    if (seq_read_left != 16'd0)
                        seq_read_left = seq_read_left - 16'd1;
                    pick_receive(r);
                end else begin
                    close_txn(r, OUT_BAD, st);
                end
            end
            PH_RNACK: begin
                if (st == ST_DATAR_NAK) begin
                    r.rx_data = w.rx_byte;
                    r.rx_valid = 1'b1;
                    seq_read_left = '0;
                    r.bus_command = CMD_STOP;
                    close_txn(r, OUT_SUCCESS, st);
                end else begin
                    close_txn(r, OUT_BAD, st);
                end
            end
            default: seq_phase = PH_IDLE;
        endcase
        return r;
    endfunction

    // begin word; event fields filled with noise
    function automatic item_t begin_word(input logic [7:0] dev, input logic [15:0] na,
                                         input logic [15:0] nw, input logic [15:0] nr);
        item_t w;
        w.mode = MODE_BEGIN;
        w.slave_addr = dev;
        w.addr_count = na;
        w.write_count = nw;
        w.read_count = nr;
        w.bus_status = 8'($urandom);
        w.rx_byte = 8'($urandom);
        w.tx_byte = 8'($urandom);
        return w;
    endfunction

    // event word; low status bits and begin fields filled with noise
    function automatic item_t event_word(input logic [7:0] st);
        item_t w;
        w.mode = MODE_EVENT;
        w.slave_addr = 8'($urandom);
        w.addr_count = 16'($urandom);
        w.write_count = 16'($urandom);
        w.read_count = 16'($urandom);
        w.bus_status = {st[7:3], 3'($urandom_range(7))};
        w.rx_byte = 8'($urandom);
        w.tx_byte = 8'($urandom);
        return w;
    endfunction

    // status that lets the current phase go on
    function automatic logic [7:0] good_status();
        case (seq_phase)
            PH_WSTART: return ST_START;
            PH_WADDR:  return ST_SLAW_ACK;
            PH_WDATA:  return ST_DATAW_ACK;
            PH_RSTART: return seq_wrote ? ST_RESTART : ST_START;
            PH_RADDR:  return ST_SLAR_ACK;
            PH_RACK:   return ST_DATAR_ACK;
            PH_RNACK:  return ST_DATAR_NAK;
            default:   return 8'($urandom);
        endcase
    endfunction

    // status that the slave refused the current byte
    function automatic logic [7:0] refused_status();
        case (seq_phase)
            PH_WADDR: return ST_SLAW_NAK;
            PH_WDATA: return ST_DATAW_NAK;
            PH_RADDR: return ST_SLAR_NAK;
            default:  return 8'($urandom);
        endcase
    endfunction

    // offer one word, predict its result once accepted, then maybe go idle
    task automatic send_word(input item_t w);
        s_tdata <= {w.tx_byte, w.rx_byte, w.bus_status, w.read_count, w.write_count,
                    w.addr_count, w.slave_addr};
        s_tuser <= w.mode;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        result_q.push_back(predict_result(w));
        words_sent++;
        // each following cycle idles with the chosen odds
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < idle_pct) @(posedge aclk);
        end
    endtask

    // stop offering and wait for every expected result
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge aclk);
    endtask

    // receiver: random stalls plus an optional long hold-off
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count < hold_until)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // compare each result word with the oldest prediction
    always @(posedge aclk) begin : check_results
        result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (result_q.size() == 0) begin
                $display("%0t: result word %h last %b with nothing expected",
                         $time, m_tdata, m_tlast);
                err_count++;
            end else begin
                exp_r = result_q.pop_front();
                if (m_tdata[2:0] !== exp_r.bus_command || m_tdata[10:3] !== exp_r.bus_byte ||
                    m_tdata[18:11] !== exp_r.rx_data || m_tdata[19] !== exp_r.rx_valid ||
                    m_tlast !== exp_r.done_res || m_tdata[21:20] !== exp_r.outcome ||
                    m_tdata[29:22] !== exp_r.failing_status || m_tdata[31:30] !== 2'b00) begin
                    $display({"%0t: mismatch expected cmd %0d byte %h rx %h/%b done %b",
                              " out %0d fail %h"},
                             $time, exp_r.bus_command, exp_r.bus_byte, exp_r.rx_data,
                             exp_r.rx_valid, exp_r.done_res, exp_r.outcome, exp_r.failing_status);
                    $display({"%0t:          actual cmd %0d byte %h rx %h/%b done %b",
                              " out %0d fail %h pad %b"},
                             $time, m_tdata[2:0], m_tdata[10:3], m_tdata[18:11], m_tdata[19],
                             m_tlast, m_tdata[21:20], m_tdata[29:22], m_tdata[31:30]);
                    err_count++;
                end
                if (exp_r.done_res) n_closed++;
                if (exp_r.done_res && exp_r.outcome == OUT_NAK) n_nak++;
                if (exp_r.done_res && exp_r.outcome == OUT_BAD) n_bad++;
                if (exp_r.rx_valid) n_rx++;
            end
        end
    end

    // event while idle is ignored
    task automatic test_idle_event();
        send_word(event_word(8'hff));
    endtask

    // full write of address and data bytes, repeated start, two-byte read
    task automatic test_write_then_read();
        send_word(begin_word(8'hff, 16'd1, 16'd1, 16'd2));
        send_word(event_word(ST_START));
        send_word(event_word(ST_SLAW_ACK));
        send_word(event_word(ST_DATAW_ACK));
        send_word(event_word(ST_DATAW_ACK));
        send_word(event_word(ST_RESTART));
        send_word(event_word(ST_SLAR_ACK));
        send_word(event_word(ST_DATAR_ACK));
        send_word(event_word(ST_DATAR_NAK));
    endtask

    // read-only transaction refused at the address byte
    task automatic test_read_nak();
        send_word(begin_word(8'h00, 16'd0, 16'd0, 16'd1));
        send_word(event_word(ST_START));
        send_word(event_word(ST_SLAR_NAK));
    endtask

    // unexpected status that masks to zero still fails the transaction
    task automatic test_zero_status();
        send_word(begin_word(8'($urandom), 16'd0, 16'd1, 16'd0));
        send_word(event_word(8'h00));
    endtask

    // largest counts, begin while busy, empty transaction
    task automatic test_count_extremes();
        send_word(begin_word(8'ha5, 16'hffff, 16'hffff, 16'hffff));
        send_word(event_word(ST_START));
        send_word(event_word(ST_SLAW_ACK));
        send_word(event_word(ST_DATAW_ACK));
        send_word(begin_word(8'h5a, 16'd0, 16'd0, 16'hffff));
        send_word(event_word(ST_START));
        send_word(event_word(ST_SLAR_ACK));
        send_word(event_word(ST_DATAR_ACK));
        send_word(begin_word(8'($urandom), 16'd0, 16'd0, 16'd0));
    endtask

    // one transaction: mostly legal status, some refusals, noise and abandons
    task automatic random_transaction();
        int na;
        int nw;
        int nr;
        int roll;
        int steps;
        if ($urandom_range(99) < 3) begin
            na = $urandom_range(65535);
            nw = $urandom_range(65535);
            nr = $urandom_range(65535);
        end else begin
            na = $urandom_range(2);
            nw = $urandom_range(4);
            nr = $urandom_range(4);
        end
        send_word(begin_word(8'($urandom), 16'(na), 16'(nw), 16'(nr)));
        steps = 0;
        while (seq_phase != PH_IDLE && steps < 40) begin
            roll = $urandom_range(999);
            if (roll < 4)
                send_word(begin_word(8'($urandom), 16'($urandom_range(2)),
                                     16'($urandom_range(3)), 16'($urandom_range(3))));
            else if (roll < 14)
                send_word(event_word(refused_status()));
            else if (roll < 24)
                send_word(event_word(8'($urandom)));
            else
                send_word(event_word(good_status()));
            steps++;
        end
        // stray event between transactions
        if ($urandom_range(9) == 0)
            send_word(event_word(8'($urandom)));
    endtask

    task automatic test_random_traffic(input int idle, input int stall, input int words);
        int target;
        idle_pct = idle;
        stall_pct = stall;
        target = words_sent + words;
        while (words_sent < target) random_transaction();
        wait_drained();
    endtask

    // long receiver hold-off while words keep coming, then a pause until drained
    task automatic test_backpressure();
        idle_pct = 0;
        stall_pct = 0;
        hold_until = cycle_count + 60;
        repeat (3) random_transaction();
        wait_drained();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_idle_event();
        test_write_then_read();
        test_read_nak();
        test_zero_status();
        test_count_extremes();
        wait_drained();
        test_backpressure();
        test_random_traffic(0, 0, 460);
        test_random_traffic(73, 0, 460);
        test_random_traffic(0, 73, 460);
        test_random_traffic(25, 25, 460);
        wait_drained();
        repeat (8) @(posedge aclk);
        $display("summary: %0d words sent, %0d transactions closed (%0d refused, %0d bad status)",
                 words_sent, n_closed, n_nak, n_bad);
        $display("summary: %0d bytes received, four idle and stall mixes plus a long hold-off",
                 n_rx);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
